// ===== src/usan_pkg.sv =====
// Package: shared types, constants and helpers of the UTF-8 stream sanitizer.
`timescale 1ns / 1ps

package usan_pkg;

	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam int unsigned MAX_BYTES      = 4;
	localparam logic [7:0]  REPL_RESET     = 8'h3F;

	// Register byte offsets on the configuration port
	localparam logic [2:0]  REG_REPLACEMENT = 3'd0;

	// Result group of one input byte; up to four output bytes
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [MAX_BYTES-1:0]      repl;
		logic [2:0]                cnt;
		logic                      last;
	} grp_t;

	// Sequence length from the lead byte; zero for a stray continuation or 0xF8+
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if ((b & 8'h80) == 8'h00) begin
			len = 3'd1;
		end else if ((b & 8'hE0) == 8'hC0) begin
			len = 3'd2;
		end else if ((b & 8'hF0) == 8'hE0) begin
			len = 3'd3;
		end else if ((b & 8'hF8) == 8'hF0) begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & 8'hC0) == 8'h80;
	endfunction

endpackage

// ===== src/utf8_stream_sanitizer.sv =====
// Top level of the UTF-8 stream sanitizer: ports, config register, front/queue/back.
`timescale 1ns / 1ps

// Usage:
//   s_* channel takes one raw byte per transaction, s_tlast on the final byte
//   of a string. m_* channel returns sanitized bytes one per transaction;
//   m_tuser[0] flags a replacement byte, m_tuser[1] marks the last output
//   caused by one input byte, m_tlast marks the final output of a string.
//   One input byte yields zero to four output bytes; over a stream the output
//   never outnumbers the input.
// Timing:
//   The front end scans held bytes plus the new byte combinationally and accepts
//   one byte per cycle while the group queue has room. The first output of a
//   byte passes through the group queue and the output register before it is
//   presented on m_*. The back end sends one byte per cycle while m_tready is
//   high, so a sustained rate of one input byte per cycle holds unless a step
//   releases several held bytes at once.
// Stall and reset:
//   When m_tready is low the output register holds, the queue fills and then
//   s_tready drops. Reset clears held sequence, queue and output valid; the
//   replacement byte returns to '?'. Write it over APB only while idle.

module utf8_stream_sanitizer
	import usan_pkg::*;
#(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last_of_string
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [0] was_replaced, [1] run_end
	output logic        m_tlast,   // string_done
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] repl_q;
	logic       reg_hit;
	logic       q_full;
	logic       push;
	grp_t       push_grp;
	logic       q_pop;
	logic       q_valid;
	grp_t       q_head;

	// Single register; byte offsets decode on the word index bit only
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_REPLACEMENT[2]);
	assign prdata  = reg_hit ? {24'd0, repl_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			repl_q <= pwdata[7:0];
		end
	end

	usan_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.repl_byte (repl_q),
		.q_full    (q_full),
		.push      (push),
		.push_grp  (push_grp)
	);

	usan_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_grp   (push_grp),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_grp   (q_head)
	);

	usan_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== src/usan_front.sv =====
// Front end: accepts bytes, holds partial sequences, builds result groups.
`timescale 1ns / 1ps

module usan_front
	import usan_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic [7:0] repl_byte,
	input  logic       q_full,
	output logic       push,
	output grp_t       push_grp
);

	logic [2:0][7:0] held_q;
	logic [1:0]      held_cnt_q;
	logic [2:0][7:0] held_d;
	logic [1:0]      held_cnt_d;
	logic            accept;
	logic [3:0][7:0] bufv;
	logic [2:0]      n;
	logic [2:0]      pos;
	logic [2:0]      k;
	logic            done;
	logic [2:0]      len;
	logic            ok;
	logic [1:0]      ix;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Scan of held bytes plus the new byte; every pass consumes at least one byte
	always_comb begin
		bufv[0] = (held_cnt_q == 2'd0) ? in_byte : held_q[0];
		bufv[1] = (held_cnt_q == 2'd1) ? in_byte : held_q[1];
		bufv[2] = (held_cnt_q == 2'd2) ? in_byte : held_q[2];
		bufv[3] = in_byte;
		n          = {1'b0, held_cnt_q} + 3'd1;
		pos        = 3'd0;
		k          = 3'd0;
		done       = 1'b0;
		held_d     = held_q;
		held_cnt_d = 2'd0;
		push_grp   = '0;
		len        = 3'd0;
		ok         = 1'b0;
		ix         = 2'd0;
		for (int t = 0; t < MAX_BYTES; t++) begin
			if (!done && (pos < n)) begin
				len = lead_len(bufv[pos[1:0]]);
				if (len == 3'd0) begin
					push_grp.bytes[k[1:0]] = repl_byte;
					push_grp.repl[k[1:0]]  = 1'b1;
					k   = k + 3'd1;
					pos = pos + 3'd1;
				end else if (({1'b0, pos} + {1'b0, len}) > {1'b0, n}) begin
					// incomplete sequence
					if (in_last) begin
						push_grp.bytes[k[1:0]] = repl_byte;
						push_grp.repl[k[1:0]]  = 1'b1;
						k = k + 3'd1;
					end else begin
						for (int h = 0; h < 3; h++) begin
							ix        = pos[1:0] + 2'(h);
							held_d[h] = bufv[ix];
						end
						held_cnt_d = 2'(n - pos);
					end
					done = 1'b1;
				end else begin
					ok = 1'b1;
					for (int j = 1; j < MAX_BYTES; j++) begin
						ix = pos[1:0] + 2'(j);
						if ((3'(j) < len) && !is_cont(bufv[ix])) begin
							ok = 1'b0;
						end
					end
					if (ok) begin
						for (int j = 0; j < MAX_BYTES; j++) begin
							if (3'(j) < len) begin
								ix = pos[1:0] + 2'(j);
								push_grp.bytes[2'(k + 3'(j))] = bufv[ix];
							end
						end
						k   = k + len;
						pos = pos + len;
					end else begin
						push_grp.bytes[k[1:0]] = repl_byte;
						push_grp.repl[k[1:0]]  = 1'b1;
						k   = k + 3'd1;
						pos = pos + 3'd1;
					end
				end
			end
		end
		push_grp.cnt  = k;
		push_grp.last = in_last;
	end

	assign push = accept && (push_grp.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= held_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

`ifndef SYNTHESIS
	a_last_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> held_cnt_q == 2'd0)
		else $error("partial sequence carried past end of string");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |-> push)
		else $error("end of string produced no output");
`endif

endmodule

// ===== src/usan_queue.sv =====
// Short queue of result groups between front and back ends.
`timescale 1ns / 1ps

module usan_queue
	import usan_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t push_grp,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output grp_t head_grp
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	grp_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_grp   = mem_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_grp;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result group pushed into full queue");
`endif

endmodule

// ===== src/usan_back.sv =====
// Back end: unpacks result groups into single output byte transactions.
`timescale 1ns / 1ps

module usan_back
	import usan_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  grp_t       q_head,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic       m_tlast
);

	grp_t       cur_q;
	logic       have_q;
	logic [1:0] idx_q;
	logic       tvalid_q;
	logic [7:0] tdata_q;
	logic [1:0] tuser_q;
	logic       tlast_q;
	logic       advance;
	logic       cur_end;
	logic       head_end;

	assign advance  = !tvalid_q || m_tready;
	assign cur_end  = ({1'b0, idx_q} + 3'd1) == cur_q.cnt;
	assign head_end = (q_head.cnt == 3'd1);
	assign q_pop    = advance && !have_q && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			idx_q    <= 2'd0;
			tvalid_q <= 1'b0;
		end else if (advance) begin
			if (have_q) begin
				tvalid_q <= 1'b1;
				idx_q    <= idx_q + 2'd1;
				if (cur_end) begin
					have_q <= 1'b0;
				end
			end else if (q_valid) begin
				tvalid_q <= 1'b1;
				idx_q    <= 2'd1;
				have_q   <= !head_end;
			end else begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (have_q) begin
				tdata_q <= cur_q.bytes[idx_q];
				tuser_q <= {cur_end, cur_q.repl[idx_q]};
				tlast_q <= cur_end && cur_q.last;
			end else if (q_valid) begin
				cur_q   <= q_head;
				tdata_q <= q_head.bytes[0];
				tuser_q <= {head_end, q_head.repl[0]};
				tlast_q <= head_end && q_head.last;
			end
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

`ifndef SYNTHESIS
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> (({1'b0, idx_q} < cur_q.cnt) && (idx_q != 2'd0)))
		else $error("output index outside current group");
`endif

endmodule

// ===== tb/testbench.sv =====
// Testbench of the UTF-8 stream sanitizer: directed rows, random strings, self-checking.
`timescale 1ns / 1ps

// The input side sends bytes in bursts with random gaps. The output side stalls
// on a changing pattern. Every accepted input byte runs through a local model
// of the sanitizer. That model fills a queue of expected output bytes, and each
// output transaction is checked against the oldest entry. The replacement byte
// is rewritten between phases, only once the block has drained.

module testbench;
	import usan_pkg::*;

	localparam int          IDLE_LIMIT    = 2000;  // cycles with no transaction at all
	localparam int          DRAIN_CYCLES  = 10;    // settle time past the last output
	localparam int          PHASE_BYTES   = 30;
	localparam int          NUM_DIR       = 25;
	localparam logic [2:0]  UNMAPPED_ADDR = 3'd4;  // no register here, writes must be dropped

	// one expected output transaction
	typedef struct packed {
		logic [7:0] data;
		logic       repl;
		logic       run_end;
		logic       done;
	} clean_byte_t;

	// directed row; where fixed is set, the output is typed in below and
	// has_out says whether the byte makes one output or none
	typedef struct packed {
		logic [7:0] data;
		logic       lst;
		logic       fixed;
		logic       has_out;
		logic [7:0] out;
		logic       out_repl;
	} dir_row_t;

	typedef enum int {
		CH_GOOD,      // well-formed sequence of 1..4 bytes
		CH_BAD_CONT,  // lead with one broken continuation byte
		CH_TRUNC,     // lead with too few continuation bytes
		CH_STRAY,     // lone continuation byte
		CH_HIGH,      // 0xF8 and above
		CH_NOISE      // any byte
	} char_kind_e;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PULSE
	} rx_mode_e;

	// Lead decode is written here as a casez on the top bits.
	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		'{8'h41, 1'b1, 1'b1, 1'b1, 8'h41,      1'b0},  // ASCII right after reset
		'{8'h00, 1'b0, 1'b1, 1'b1, 8'h00,      1'b0},  // lowest byte
		'{8'h7F, 1'b0, 1'b1, 1'b1, 8'h7F,      1'b0},
		'{8'hFF, 1'b0, 1'b1, 1'b1, REPL_RESET, 1'b1},  // highest byte is invalid
		'{8'h80, 1'b0, 1'b1, 1'b1, REPL_RESET, 1'b1},  // stray continuation
		'{8'hF8, 1'b0, 1'b1, 1'b1, REPL_RESET, 1'b1},  // first of the 0xF8+ range
		'{8'hC3, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},  // pending two-byte lead
		'{8'hA9, 1'b0, 1'b0, 1'b0, 8'h00,      1'b0},  // completes it
		'{8'hE2, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h82, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'hAC, 1'b0, 1'b0, 1'b0, 8'h00,      1'b0},  // three-byte release
		'{8'hF0, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h9F, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h98, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h80, 1'b0, 1'b0, 1'b0, 8'h00,      1'b0},  // four-byte release
		'{8'hF0, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},  // bad byte held until complete
		'{8'h41, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h42, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h43, 1'b0, 1'b0, 1'b0, 8'h00,      1'b0},  // replacement, then rescan
		'{8'hE2, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h82, 1'b1, 1'b1, 1'b1, REPL_RESET, 1'b1},  // string ends mid-sequence
		'{8'hC3, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h3F, 1'b0, 1'b0, 1'b0, 8'h00,      1'b0},  // raw byte equal to replacement
		'{8'hF0, 1'b0, 1'b1, 1'b0, 8'h00,      1'b0},
		'{8'h41, 1'b1, 1'b1, 1'b1, REPL_RESET, 1'b1}   // incomplete at end, 0x41 dropped
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// sanitizer model state
	logic [7:0]  repl_val = REPL_RESET;
	logic [7:0]  held_q [3];
	int          held_n = 0;
	int          seq_len = 0;

	clean_byte_t due_bytes [$];
	int          fail_cnt = 0;
	int          burst_left = 0;
	int          bytes_sent = 0;
	int          idle_cycles = 0;
	int          rx_left = 0;
	int unsigned rx_tick = 0;
	rx_mode_e    rx_mode = RX_ALWAYS;

	utf8_stream_sanitizer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Sequence length announced by a lead byte; 0 for 10xxxxxx and 0xF8+.
	function automatic int lead_span(input logic [7:0] b);
		casez (b)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	// One input byte through the model. Held bytes plus the new one form a
	// window of up to four; the window is scanned from the front, and a lead
	// whose sequence overruns the window is either held or, at string end,
	// replaced once with the rest of the window dropped.
	function automatic void sanitize_step(input logic [7:0] b, input logic lst,
			input bit record);
		logic [7:0]  win [4];
		clean_byte_t res [$];
		int          n;
		int          i;
		int          j;
		int          len;
		bit          ok;
		n = 0;
		i = 0;
		for (j = 0; j < held_n; j++) begin
			win[n] = held_q[j];
			n++;
		end
		win[n] = b;
		n++;
		held_n = 0;
		seq_len = 0;
		while (i < n) begin
			len = lead_span(win[i]);
			if (len == 0) begin
				res.push_back('{repl_val, 1'b1, 1'b0, 1'b0});
				i++;
			end else if (i + len > n) begin
				if (lst) begin
					res.push_back('{repl_val, 1'b1, 1'b0, 1'b0});
				end else begin
					while (i < n) begin
						held_q[held_n] = win[i];
						held_n++;
						i++;
					end
					seq_len = len;
				end
				break;
			end else begin
				ok = 1'b1;
				for (j = 1; j < len; j++) begin
					if (win[i + j][7:6] != 2'b10) ok = 1'b0;
				end
				if (ok) begin
					for (j = 0; j < len; j++) res.push_back('{win[i + j], 1'b0, 1'b0, 1'b0});
					i += len;
				end else begin
					// only the lead is replaced; its followers get a fresh look
					res.push_back('{repl_val, 1'b1, 1'b0, 1'b0});
					i++;
				end
			end
		end
		if (res.size() > 0) begin
			res[res.size() - 1].run_end = 1'b1;
			res[res.size() - 1].done    = lst;
		end
		if (record) begin
			for (j = 0; j < res.size(); j++) due_bytes.push_back(res[j]);
		end
	endfunction

	// Sends one byte and runs it through the model once it is accepted.
	// valid stays high inside a burst and is lowered in the gap after each burst.
	task automatic send_byte(input logic [7:0] b, input logic lst, input bit record);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		sanitize_step(b, lst, record);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == REG_REPLACEMENT) repl_val = data[7:0];
	endtask

	// Stop sending, let every expected byte arrive, then give the pipeline
	// time to show anything extra.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_lead(input int len);
		case (len)
			1:       return {1'b0, 7'($urandom)};
			2:       return {3'b110, 5'($urandom)};
			3:       return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	function automatic logic [7:0] rand_cont();
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic logic [7:0] rand_non_cont();
		logic [7:0] b;
		do b = 8'($urandom); while (b[7:6] == 2'b10);
		return b;
	endfunction

	// One string of 1..5 characters, mostly well-formed, last byte flagged.
	task automatic send_text();
		logic [7:0] seq [$];
		char_kind_e kind;
		int         nchars;
		int         c;
		int         k;
		int         len;
		int         bad;
		int         r;
		nchars = $urandom_range(1, 5);
		for (c = 0; c < nchars; c++) begin
			r = $urandom_range(0, 99);
			if (r < 65)      kind = CH_GOOD;
			else if (r < 75) kind = CH_BAD_CONT;
			else if (r < 85) kind = CH_TRUNC;
			else if (r < 90) kind = CH_STRAY;
			else if (r < 95) kind = CH_HIGH;
			else             kind = CH_NOISE;
			case (kind)
				CH_GOOD: begin
					len = $urandom_range(1, 4);
					seq.push_back(rand_lead(len));
					for (k = 1; k < len; k++) seq.push_back(rand_cont());
				end
				CH_BAD_CONT: begin
					len = $urandom_range(2, 4);
					bad = $urandom_range(1, len - 1);
					seq.push_back(rand_lead(len));
					for (k = 1; k < len; k++) seq.push_back(k == bad ? rand_non_cont() : rand_cont());
				end
				CH_TRUNC: begin
					len = $urandom_range(2, 4);
					seq.push_back(rand_lead(len));
					for (k = 1; k < $urandom_range(1, len - 1); k++) seq.push_back(rand_cont());
				end
				CH_STRAY: seq.push_back(rand_cont());
				CH_HIGH:  seq.push_back({5'b11111, 3'($urandom)});
				default:  seq.push_back(8'($urandom));
			endcase
		end
		for (k = 0; k < seq.size(); k++) send_byte(seq[k], k == seq.size() - 1, 1'b1);
	endtask

	// Output checker and receiver stall pattern. Handshake is judged on the
	// values before this edge; the new m_tready takes effect after it.
	always @(posedge clk) begin
		clean_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_bytes.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected output: data=%h repl=%b run_end=%b done=%b",
						m_tdata, m_tuser[0], m_tuser[1], m_tlast);
			end else begin
				want = due_bytes.pop_front();
				if (m_tdata !== want.data || m_tuser[0] !== want.repl
						|| m_tuser[1] !== want.run_end || m_tlast !== want.done) begin
					fail_cnt++;
					if (fail_cnt <= 10) begin
						$display("output mismatch: expected data=%h repl=%b run_end=%b done=%b",
							want.data, want.repl, want.run_end, want.done);
						$display("                 got      data=%h repl=%b run_end=%b done=%b",
							m_tdata, m_tuser[0], m_tuser[1], m_tlast);
					end
				end
			end
		end
		rx_tick++;
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(5, 60);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom);
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= (rx_tick % 3 != 0);
		endcase
	end

	// Watchdog: any stretch without a transaction on either stream or the
	// register port that runs this long means the block has hung.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] repl_plan [4];
		int         d;
		int         ph;
		repl_plan[0] = 8'h00;
		repl_plan[1] = 8'hFF;
		repl_plan[2] = 8'($urandom);
		repl_plan[3] = 8'h80;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows with the reset replacement byte. Typed rows still go
		// through the model so that its held bytes stay in step.
		for (d = 0; d < NUM_DIR; d++) begin
			if (DIR_ROWS[d].fixed && DIR_ROWS[d].has_out)
				due_bytes.push_back('{DIR_ROWS[d].out, DIR_ROWS[d].out_repl, 1'b1,
					DIR_ROWS[d].lst});
			send_byte(DIR_ROWS[d].data, DIR_ROWS[d].lst, !DIR_ROWS[d].fixed);
		end
		drain();

		// Random phases, one replacement setting each. Upper data bits are
		// random since only the low byte lands in the register; a write to an
		// unmapped address must leave the setting alone.
		for (ph = 0; ph < 4; ph++) begin
			reg_write(REG_REPLACEMENT, {24'($urandom), repl_plan[ph]});
			if (ph == 1) reg_write(UNMAPPED_ADDR, $urandom);
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES) send_text();
			drain();
		end

		if (fail_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
